// ----- hw/rtl/mbrc_pkg.sv -----
`timescale 1ns / 1ps

package mbrc_pkg;

   localparam int ADDR_WIDTH = 32;
   localparam int WORD_BYTES = 4;

   // keeps the low ADDR_WIDTH bits of an address, at most 32 of them
   localparam logic [31:0] ADDR_MASK       = 32'((65'd1 << ADDR_WIDTH) - 65'd1);
   localparam logic [31:0] WORD_ALIGN_MASK = 32'hFFFF_FFFC;
   localparam logic [31:0] ADDR_STEP       = 32'(WORD_BYTES);
   localparam logic [3:0]  FULL_MASK       = 4'hF;
   localparam logic [3:0]  LANE0_MASK      = 4'h1;

   localparam logic [1:0]  CMD_SETUP = 2'd0;
   localparam logic [1:0]  CMD_READ  = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'd0,
      ST_CONN      = 4'd1,
      ST_RD_WORD   = 4'd2,
      ST_RD_BYTE   = 4'd3,
      ST_RD_IPK    = 4'd4,
      ST_RD_STALL  = 4'd5,
      ST_IPK_STALL = 4'd6,
      ST_WR_WORD   = 4'd7,
      ST_WR_BYTE   = 4'd8,
      ST_WR_PEND   = 4'd9
   } fsm_state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic        ipk;
      logic        byte_acc;
      logic [31:0] address;
      logic        rx_valid;
      logic [31:0] rx_data;
      logic        tx_free;
      logic        mem_ack;
      logic [31:0] mem_rdata;
      logic        mem_rdata_last;
   } item_type;

   typedef struct packed {
      logic        rx_ack;
      logic        tx_valid;
      logic [31:0] tx_word;
      logic [31:0] tx_channel;
      logic        tx_setup_reply;
      logic        tx_more;
      logic [31:0] mem_address;
      logic [31:0] mem_write_data;
      logic [3:0]  mem_byte_mask;
      logic        mem_read_en;
      logic        mem_write_en;
      logic        idle;
   } result_type;

   typedef struct packed {
      fsm_state_type state;
      result_type    res;
      logic          set_chan;
      logic          set_addr;
      logic [31:0]   addr;
      logic          set_mask;
      logic [3:0]    mask;
      logic          set_lane;
      logic [1:0]    lane;
   } start_type;

endpackage

// ----- hw/rtl/mbrc_start.sv -----
`timescale 1ns / 1ps

module mbrc_start import mbrc_pkg::*; (
   input  item_type    item,
   input  logic [15:0] reply_port_id,
   output start_type   start
);

   logic [31:0] addr_word;
   logic [31:0] addr_byte;

   assign addr_word = item.address & ADDR_MASK;
   assign addr_byte = item.address & WORD_ALIGN_MASK & ADDR_MASK;

   always_comb begin
      start       = '0;
      start.state = ST_CONN;
      if (item.rx_valid) begin
         if (item.command == CMD_SETUP) begin
            if (item.tx_free) begin
               start.res.rx_ack         = 1'b1;
               start.res.tx_valid       = 1'b1;
               start.res.tx_word        = {16'd0, reply_port_id};
               start.res.tx_channel     = item.address;
               start.res.tx_setup_reply = 1'b1;
               start.set_chan           = 1'b1;
            end
         end else begin
            start.res.rx_ack = 1'b1;
            start.set_addr   = 1'b1;
            if (item.command == CMD_READ) begin
               start.res.mem_read_en = 1'b1;
               if (item.ipk) begin
                  start.addr  = addr_word;
                  start.state = ST_RD_IPK;
               end else if (item.byte_acc) begin
                  start.addr     = addr_byte;
                  start.set_lane = 1'b1;
                  start.lane     = item.address[1:0];
                  start.state    = ST_RD_BYTE;
               end else begin
                  start.addr  = addr_word;
                  start.state = ST_RD_WORD;
               end
               start.res.mem_address = start.addr;
            end else begin
               // write header (also any unknown command)
               start.set_mask = 1'b1;
               if (item.byte_acc) begin
                  start.addr     = addr_byte;
                  start.mask     = LANE0_MASK << item.address[1:0];
                  start.set_lane = 1'b1;
                  start.lane     = item.address[1:0];
                  start.state    = ST_WR_BYTE;
               end else begin
                  start.addr  = addr_word;
                  start.mask  = FULL_MASK;
                  start.state = ST_WR_WORD;
               end
            end
         end
      end
   end

endmodule

// ----- hw/rtl/mbrc_ctrl.sv -----
`timescale 1ns / 1ps

module mbrc_ctrl import mbrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  item_type    item,
   input  logic [15:0] reply_port_id,
   output result_type  result
);

   fsm_state_type state_ff, state_in;
   logic [31:0]   chan_ff, chan_in;
   logic [31:0]   addr_ff, addr_in;
   logic [3:0]    mask_ff, mask_in;
   logic [31:0]   hold_ff, hold_in;
   logic [1:0]    lane_ff, lane_in;
   logic          held_last_ff, held_last_in;

   start_type   start;
   logic        take_start;
   logic [4:0]  shift;
   logic [31:0] rd_shifted;
   logic [31:0] rd_value;
   logic [31:0] wr_value;
   logic [31:0] addr_step;

   mbrc_start u_start (
      .item          (item),
      .reply_port_id (reply_port_id),
      .start         (start)
   );

   assign shift      = {lane_ff, 3'b000};
   assign rd_shifted = item.mem_rdata >> shift;
   assign rd_value   = (state_ff == ST_RD_BYTE) ? {24'd0, rd_shifted[7:0]} : item.mem_rdata;
   // bits pushed past the top of the word are dropped
   assign wr_value   = (state_ff == ST_WR_BYTE) ? (item.rx_data << shift) : item.rx_data;
   assign addr_step  = (addr_ff + ADDR_STEP) & ADDR_MASK;

   // outputs
   always_comb begin
      result     = '0;
      take_start = 1'b0;
      result.idle = (state_ff == ST_IDLE) || (state_ff == ST_CONN);
      unique case (state_ff)
         ST_IDLE: begin
            if (item.rx_valid && item.tx_free) begin
               result.rx_ack = 1'b1;
               if (item.command == CMD_SETUP) begin
                  result.tx_valid       = 1'b1;
                  result.tx_word        = {16'd0, reply_port_id};
                  result.tx_channel     = item.address;
                  result.tx_setup_reply = 1'b1;
               end
            end
         end
         ST_CONN: begin
            take_start = 1'b1;
         end
         ST_RD_WORD, ST_RD_BYTE: begin
            if (item.mem_ack) begin
               if (item.tx_free) begin
                  result.tx_valid   = 1'b1;
                  result.tx_word    = rd_value;
                  result.tx_channel = chan_ff;
                  take_start        = 1'b1;
               end
            end else begin
               result.mem_address = addr_ff;
               result.mem_read_en = 1'b1;
            end
         end
         ST_RD_IPK: begin
            if (item.mem_ack) begin
               if (item.tx_free) begin
                  result.tx_valid   = 1'b1;
                  result.tx_word    = item.mem_rdata;
                  result.tx_channel = chan_ff;
                  result.tx_more    = !item.mem_rdata_last;
                  if (item.mem_rdata_last) begin
                     take_start = 1'b1;
                  end else begin
                     result.mem_address = addr_step;
                     result.mem_read_en = 1'b1;
                  end
               end
            end else begin
               result.mem_address = addr_ff;
               result.mem_read_en = 1'b1;
            end
         end
         ST_RD_STALL: begin
            if (item.tx_free) begin
               result.tx_valid   = 1'b1;
               result.tx_word    = hold_ff;
               result.tx_channel = chan_ff;
               take_start        = 1'b1;
            end
         end
         ST_IPK_STALL: begin
            if (item.tx_free) begin
               result.tx_valid   = 1'b1;
               result.tx_word    = hold_ff;
               result.tx_channel = chan_ff;
               result.tx_more    = !held_last_ff;
               if (held_last_ff) begin
                  take_start = 1'b1;
               end else begin
                  result.mem_address = addr_step;
                  result.mem_read_en = 1'b1;
               end
            end
         end
         ST_WR_WORD, ST_WR_BYTE: begin
            if (item.rx_valid) begin
               result.rx_ack         = 1'b1;
               result.mem_address    = addr_ff;
               result.mem_write_data = wr_value;
               result.mem_byte_mask  = mask_ff;
               result.mem_write_en   = 1'b1;
            end
         end
         ST_WR_PEND: begin
            if (item.mem_ack) begin
               take_start = 1'b1;
            end else begin
               result.mem_address    = addr_ff;
               result.mem_write_data = hold_ff;
               result.mem_byte_mask  = mask_ff;
               result.mem_write_en   = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // a chained request; a setup reply takes the transmit port over
      if (take_start) begin
         result.rx_ack      = start.res.rx_ack;
         result.mem_address = start.res.mem_address;
         result.mem_read_en = start.res.mem_read_en;
         if (start.res.tx_valid) begin
            result.tx_valid       = 1'b1;
            result.tx_word        = start.res.tx_word;
            result.tx_channel     = start.res.tx_channel;
            result.tx_setup_reply = start.res.tx_setup_reply;
            result.tx_more        = start.res.tx_more;
         end
      end
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      chan_in      = chan_ff;
      addr_in      = addr_ff;
      mask_in      = mask_ff;
      hold_in      = hold_ff;
      lane_in      = lane_ff;
      held_last_in = held_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item.rx_valid && item.tx_free && (item.command == CMD_SETUP)) begin
               chan_in  = item.address;
               state_in = ST_CONN;
            end
         end
         ST_RD_WORD, ST_RD_BYTE: begin
            if (item.mem_ack && !item.tx_free) begin
               hold_in  = rd_value;
               state_in = ST_RD_STALL;
            end
         end
         ST_RD_IPK: begin
            if (item.mem_ack) begin
               if (item.tx_free) begin
                  if (!item.mem_rdata_last) begin
                     addr_in = addr_step;
                  end
               end else begin
                  hold_in      = item.mem_rdata;
                  held_last_in = item.mem_rdata_last;
                  state_in     = ST_IPK_STALL;
               end
            end
         end
         ST_IPK_STALL: begin
            if (item.tx_free && !held_last_ff) begin
               addr_in  = addr_step;
               state_in = ST_RD_IPK;
            end
         end
         ST_WR_WORD, ST_WR_BYTE: begin
            if (item.rx_valid) begin
               hold_in  = wr_value;
               state_in = ST_WR_PEND;
            end
         end
         ST_CONN, ST_RD_STALL, ST_WR_PEND: begin
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (take_start) begin
         state_in = start.state;
         if (start.set_chan) begin
            chan_in = start.res.tx_channel;
         end
         if (start.set_addr) begin
            addr_in = start.addr;
         end
         if (start.set_mask) begin
            mask_in = start.mask;
         end
         if (start.set_lane) begin
            lane_in = start.lane;
         end
      end
   end

   // state only moves when a beat is stepped through
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chan_ff      <= '0;
         addr_ff      <= '0;
         mask_ff      <= '0;
         hold_ff      <= '0;
         lane_ff      <= '0;
         held_last_ff <= 1'b0;
      end else if (step) begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         addr_ff      <= addr_in;
         mask_ff      <= mask_in;
         hold_ff      <= hold_in;
         lane_ff      <= lane_in;
         held_last_ff <= held_last_in;
      end
   end

endmodule

// ----- hw/rtl/memory_bank_request_controller.sv -----
`timescale 1ns / 1ps

// Memory bank request controller, one step of the bank-side controller per beat.
// req channel: one beat carries everything the controller samples in a cycle
// (decoded command, address, rx data, tx flow control, memory response).
// rsp channel: one beat per req beat, carrying what the controller drives in
// that cycle (rx_ack, the transmit word and channel, the memory request, idle).
// csr channel: writes the 16-bit port id sent back on a connection setup;
// only write it while no req beat is outstanding.
// rsp valid rises after the edge that accepts the req beat: the beat is held
// in an input register, the controller step runs in combinational logic, and
// the result lands in the rsp register at the edge that steps the controller,
// as does the state update; one beat is taken every cycle while rsp_ready is high.
// After reset the controller is unconnected and the port id is zero.
// While a held rsp waits on rsp_ready, the rsp register holds, the input
// register fills, req_ready drops, nothing is lost, controller state does not move.

module memory_bank_request_controller import mbrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic        req_ipk,
   input  logic        req_byte,
   input  logic [31:0] req_address,
   input  logic        req_rx_valid,
   input  logic [31:0] req_rx_data,
   input  logic        req_tx_free,
   input  logic        req_mem_ack,
   input  logic [31:0] req_mem_rdata,
   input  logic        req_mem_rdata_last,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_rx_ack,
   output logic        rsp_tx_valid,
   output logic [31:0] rsp_tx_word,
   output logic [31:0] rsp_tx_channel,
   output logic        rsp_tx_setup_reply,
   output logic        rsp_tx_more,
   output logic [31:0] rsp_mem_address,
   output logic [31:0] rsp_mem_write_data,
   output logic [3:0]  rsp_mem_byte_mask,
   output logic        rsp_mem_read_en,
   output logic        rsp_mem_write_en,
   output logic        rsp_idle,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic        in_valid_ff, in_valid_in;
   item_type    in_item_ff, in_item_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_res_ff, rsp_res_in;
   logic [15:0] port_id_ff, port_id_in;

   logic        advance;
   logic        req_fire;
   result_type  step_res;

   mbrc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .item          (in_item_ff),
      .reply_port_id (port_id_ff),
      .result        (step_res)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      in_item_in.command        = req_command;
      in_item_in.ipk            = req_ipk;
      in_item_in.byte_acc       = req_byte;
      in_item_in.address        = req_address;
      in_item_in.rx_valid       = req_rx_valid;
      in_item_in.rx_data        = req_rx_data;
      in_item_in.tx_free        = req_tx_free;
      in_item_in.mem_ack        = req_mem_ack;
      in_item_in.mem_rdata      = req_mem_rdata;
      in_item_in.mem_rdata_last = req_mem_rdata_last;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_res_in = advance ? step_res : rsp_res_ff;
      port_id_in = (csr_valid && csr_ready) ? csr_data : port_id_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         port_id_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         port_id_ff   <= port_id_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rx_ack         = rsp_res_ff.rx_ack;
   assign rsp_tx_valid       = rsp_res_ff.tx_valid;
   assign rsp_tx_word        = rsp_res_ff.tx_word;
   assign rsp_tx_channel     = rsp_res_ff.tx_channel;
   assign rsp_tx_setup_reply = rsp_res_ff.tx_setup_reply;
   assign rsp_tx_more        = rsp_res_ff.tx_more;
   assign rsp_mem_address    = rsp_res_ff.mem_address;
   assign rsp_mem_write_data = rsp_res_ff.mem_write_data;
   assign rsp_mem_byte_mask  = rsp_res_ff.mem_byte_mask;
   assign rsp_mem_read_en    = rsp_res_ff.mem_read_en;
   assign rsp_mem_write_en   = rsp_res_ff.mem_write_en;
   assign rsp_idle           = rsp_res_ff.idle;

endmodule
